>>> sv/mtf_pkg.sv
// Shared types and constants for the move-to-front list.
`default_nettype none

package mtf_pkg;

	// Default sizing of the list
	localparam int DEPTH_DEF    = 128;
	localparam int ID_WIDTH_DEF = 16;

	// Fixed widths of the request and result fields
	localparam int FIELD_W = 16;
	localparam int MODE_W  = 2;

	// Request operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PROMOTE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} state_t;

	// Per-cell update operations
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_PROMOTE,
		CELL_PULL
	} cell_op_t;

	// Command broadcast from the sequencer to every cell
	typedef struct packed {
		logic     clear_pre;
		logic     scan;
		cell_op_t op;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> sv/move_to_front_list.sv
// Flow: a request is captured in IDLE; insert, an unused mode, or promote/remove
//   on a list of at most one entry goes straight to APPLY; promote/remove on a list
//   of two or more entries passes through SCAN, the match flag rippling one cell per
//   cycle, then APPLY. One request in flight: APPLY waits for the prior result to be
//   taken; a new request is accepted in IDLE, entered as the result is registered.
// Reset: arst_n clears the entry count, sequencer and result valid; ids need no clear.
`default_nettype none

module move_to_front_list #(
	parameter int DEPTH    = mtf_pkg::DEPTH_DEF,
	parameter int ID_WIDTH = mtf_pkg::ID_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [mtf_pkg::MODE_W-1:0]   mode,
	input  wire logic [mtf_pkg::FIELD_W-1:0]  item_id,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output logic      [mtf_pkg::FIELD_W-1:0]  front_id,
	output logic                              list_empty,
	output logic                              hit,
	output logic                              rejected
);
	import mtf_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	// Sequencer and request registers
	state_t              state_q;
	state_t              state_d;
	logic [MODE_W-1:0]   mode_q;
	logic [ID_WIDTH-1:0] key_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [IW-1:0]       scan_cnt_q;

	// Result register
	logic                res_valid_q;
	logic [FIELD_W-1:0]  front_id_q;
	logic                list_empty_q;
	logic                hit_q;
	logic                rejected_q;

	// Cell chain nets
	logic [ID_WIDTH-1:0] id_w    [DEPTH];
	logic                pre_w   [DEPTH];
	logic                match_w [DEPTH];
	cell_cmd_t           cmd;

	// Decode
	logic                req_acc;
	logic                apply_fire;
	logic                needs_scan;
	logic                scan_last;
	logic [CW-1:0]       count_m1;
	logic [IW-1:0]       last_idx;
	logic                found;
	logic                full;
	logic                hit_w;
	logic                rej_w;
	cell_op_t            op_w;
	logic [ID_WIDTH-1:0] front_next;

	// Build the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ID_WIDTH-1:0] l_id;
		logic [ID_WIDTH-1:0] r_id;
		logic                l_pre;
		logic                l_match;
		logic                r_pre;

		if (i == 0) begin : g_head
			assign l_id    = key_q;
			assign l_pre   = 1'b0;
			assign l_match = 1'b0;
		end else begin : g_body
			assign l_id    = id_w[i-1];
			assign l_pre   = pre_w[i-1];
			assign l_match = match_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_id  = id_w[i];
			assign r_pre = 1'b0;
		end else begin : g_mid
			assign r_id  = id_w[i+1];
			assign r_pre = pre_w[i+1];
		end

		mtf_cell #(
			.ID_WIDTH(ID_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.key       (key_q),
			.left_id   (l_id),
			.right_id  (r_id),
			.left_pre  (l_pre),
			.left_match(l_match),
			.right_pre (r_pre),
			.id        (id_w[i]),
			.pre       (pre_w[i]),
			.match     (match_w[i])
		);
	end

	// Decode the request against the settled chain
	assign req_acc    = req_valid && req_ready;
	assign needs_scan = ((mode == MODE_PROMOTE) || (mode == MODE_REMOVE)) &&
		(count_q >= CW'(2));
	assign scan_last  = (CW'(scan_cnt_q) == (count_q - CW'(2)));
	assign count_m1   = count_q - CW'(1);
	assign last_idx   = count_m1[IW-1:0];
	assign found      = (count_q != '0) && (pre_w[last_idx] || match_w[last_idx]);
	assign full       = (count_q >= CW'(DEPTH));

	always_comb begin
		hit_w      = 1'b0;
		rej_w      = 1'b0;
		op_w       = CELL_HOLD;
		count_d    = count_q;
		front_next = id_w[0];
		case (mode_q)
			MODE_INSERT: begin
				if (full) begin
					rej_w = 1'b1;
				end else begin
					op_w       = CELL_PUSH;
					count_d    = count_q + CW'(1);
					front_next = key_q;
				end
			end
			MODE_PROMOTE: begin
				if (found) begin
					hit_w      = 1'b1;
					op_w       = CELL_PROMOTE;
					front_next = key_q;
				end
			end
			MODE_REMOVE: begin
				if (found) begin
					hit_w      = 1'b1;
					op_w       = CELL_PULL;
					count_d    = count_m1;
					front_next = pre_w[1] ? id_w[1] : id_w[0];
				end
			end
			default: begin
				op_w = CELL_HOLD;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = needs_scan ? ST_SCAN : ST_APPLY;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (apply_fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_ready     = 1'b0;
		apply_fire    = 1'b0;
		cmd.clear_pre = 1'b0;
		cmd.scan      = 1'b0;
		cmd.op        = CELL_HOLD;
		case (state_q)
			ST_IDLE: begin
				req_ready     = 1'b1;
				cmd.clear_pre = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_APPLY: begin
				apply_fire = !res_valid_q || res_ready;
				if (apply_fire) begin
					cmd.op = op_w;
				end
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// Hold state, count and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (apply_fire) begin
				count_q <= count_d;
			end
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IW'(1);
			end else begin
				scan_cnt_q <= '0;
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (req_acc) begin
			mode_q <= mode;
			key_q  <= ID_WIDTH'(item_id);
		end
	end

	// Result valid: set on apply, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (apply_fire) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (apply_fire) begin
			front_id_q   <= (count_d == '0) ? '0 : FIELD_W'(front_next);
			list_empty_q <= (count_d == '0);
			hit_q        <= hit_w;
			rejected_q   <= rej_w;
		end
	end

	assign res_valid  = res_valid_q;
	assign front_id   = front_id_q;
	assign list_empty = list_empty_q;
	assign hit        = hit_q;
	assign rejected   = rejected_q;

	// Count never runs past the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// Count moves only when a result is applied
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_APPLY) |=> $stable(count_q))
		else $error("entry count changed outside apply");

	// A scan runs only over a list of two or more entries
	a_scan_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (count_q >= CW'(2)))
		else $error("scan on a short list");

	// Hit and rejected never come together
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(hit_q && rejected_q))
		else $error("hit and rejected both set");

	// An empty list reports a zero front id
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && list_empty_q) |-> (front_id_q == '0))
		else $error("empty list with nonzero front id");

endmodule

`default_nettype wire

>>> sv/mtf_cell.sv
// One list slot: holds an id and a "match seen ahead of me" flag.
`default_nettype none

module mtf_cell #(
	parameter int ID_WIDTH = mtf_pkg::ID_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mtf_pkg::cell_cmd_t  cmd,
	input  wire logic [ID_WIDTH-1:0] key,
	input  wire logic [ID_WIDTH-1:0] left_id,
	input  wire logic [ID_WIDTH-1:0] right_id,
	input  wire logic                left_pre,
	input  wire logic                left_match,
	input  wire logic                right_pre,
	output logic      [ID_WIDTH-1:0] id,
	output logic                     pre,
	output logic                     match
);
	import mtf_pkg::*;

	logic [ID_WIDTH-1:0] id_q;
	logic [ID_WIDTH-1:0] id_d;
	logic                pre_q;
	logic                pre_d;

	// Compare the held id against the request key
	assign match = (id_q == key);

	// Ripple the match-ahead flag one slot per scan cycle
	always_comb begin
		pre_d = pre_q;
		if (cmd.clear_pre) begin
			pre_d = 1'b0;
		end else if (cmd.scan) begin
			pre_d = left_pre | left_match;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q <= 1'b0;
		end else begin
			pre_q <= pre_d;
		end
	end

	// Select the next id: shift toward the back, toward the front, or hold
	always_comb begin
		case (cmd.op)
			CELL_HOLD:    id_d = id_q;
			CELL_PUSH:    id_d = left_id;
			CELL_PROMOTE: id_d = pre_q ? id_q : left_id;
			CELL_PULL:    id_d = right_pre ? right_id : id_q;
			default:      id_d = id_q;
		endcase
	end

	always_ff @(posedge clk) begin
		id_q <= id_d;
	end

	assign id  = id_q;
	assign pre = pre_q;

endmodule

`default_nettype wire
